[rtl/pmbo_pkg.sv]
// Shared definitions for the priority mailbox with overwrite-oldest rings.
// Used by pmbo_ptrs and priority_mailbox_overwrite; depends on nothing.
package pmbo_pkg;

  // Update applied to the ring pointers of one level.
  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_PUSH,
    PTR_POP
  } pmbo_ptr_op_e;

endpackage

[rtl/pmbo_mem.sv]
// Message slot storage: one row per priority level, one word per ring entry.
// Single write port and one registered read port; depends on nothing.
module pmbo_mem #(
  parameter int LEVELS     = 4,
  parameter int RING_DEPTH = 8,
  parameter int MSG_WIDTH  = 32,
  parameter int LW         = 2,
  parameter int PW         = 3
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [LW-1:0]        wr_level_i,
  input  logic [PW-1:0]        wr_pos_i,
  input  logic [MSG_WIDTH-1:0] wr_data_i,
  input  logic                 rd_en_i,
  input  logic [LW-1:0]        rd_level_i,
  input  logic [PW-1:0]        rd_pos_i,
  output logic [MSG_WIDTH-1:0] rd_data_o
);

  logic [MSG_WIDTH-1:0] mem_q [LEVELS][RING_DEPTH];

  // Write port; slots are not reset.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_level_i][wr_pos_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_level_i][rd_pos_i];
    end
  end

endmodule

[rtl/pmbo_ptrs.sv]
// Head, tail and fill count of every priority ring, read and updated at one level.
// Depends on pmbo_pkg for the pointer update code.
module pmbo_ptrs #(
  parameter int LEVELS     = 4,
  parameter int RING_DEPTH = 8,
  parameter int LW         = 2,
  parameter int PW         = 3,
  parameter int CW         = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [LW-1:0]         level_i,
  input  pmbo_pkg::pmbo_ptr_op_e op_i,
  output logic [PW-1:0]         head_o,
  output logic [PW-1:0]         tail_o,
  output logic [CW-1:0]         count_o,
  output logic                  full_o
);
  import pmbo_pkg::*;

  logic [PW-1:0] head_q  [LEVELS];
  logic [PW-1:0] tail_q  [LEVELS];
  logic [CW-1:0] count_q [LEVELS];
  logic [PW-1:0] head_next;
  logic [PW-1:0] tail_next;

  // Selected level view.
  assign head_o  = head_q[level_i];
  assign tail_o  = tail_q[level_i];
  assign count_o = count_q[level_i];
  assign full_o  = (count_q[level_i] == CW'(RING_DEPTH));

  // Ring positions wrap at the depth.
  assign head_next = (head_o == PW'(RING_DEPTH - 1)) ? '0 : head_o + PW'(1);
  assign tail_next = (tail_o == PW'(RING_DEPTH - 1)) ? '0 : tail_o + PW'(1);

  // A push into a full ring moves the head too, dropping the oldest message.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      case (op_i)
        PTR_PUSH: begin
          tail_q[level_i] <= tail_next;
          if (full_o) begin
            head_q[level_i] <= head_next;
          end else begin
            count_q[level_i] <= count_o + CW'(1);
          end
        end
        PTR_POP: begin
          head_q[level_i]  <= head_next;
          count_q[level_i] <= count_o - CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/priority_mailbox_overwrite.sv]
// Priority mailbox: one overwrite-oldest ring per priority level.
// Transmit: the push state writes the slot and the result strobe is registered from it;
// a new transaction may start once busy drops. Receive: the level scan checks
// one ring per cycle from level 0 upward and reads the first non-empty one, or
// reports no message when every ring is empty. The receiver cannot stall.
// Reset (async, active low) empties every ring; message slots are not cleared.
module priority_mailbox_overwrite #(
  parameter int LEVELS     = 4,
  parameter int RING_DEPTH = 8,
  parameter int MSG_WIDTH  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [1:0]  priority_req_i,
  input  logic [31:0] message_i,
  output logic        done_o,
  output logic [31:0] out_message_o,
  output logic        no_message_o,
  output logic [1:0]  served_priority_o,
  output logic [3:0]  stored_count_o,
  output logic        overwrote_o
);
  import pmbo_pkg::*;

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PUSH = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [LW-1:0]        lvl_q, lvl_d;
  logic [MSG_WIDTH-1:0] msg_q;
  logic [LW-1:0]        prio_sat;
  logic [MSG_WIDTH+31:0] msg_in_ext;

  pmbo_ptr_op_e         ptr_op;
  logic [PW-1:0]        head;
  logic [PW-1:0]        tail;
  logic [CW-1:0]        count;
  logic                 full;
  logic                 mem_we;
  logic                 mem_re;
  logic [MSG_WIDTH-1:0] rd_data;
  logic [MSG_WIDTH+31:0] rd_ext;

  logic                 done_q, done_d;
  logic [31:0]          res_msg_q, res_msg_d;
  logic                 res_empty_q, res_empty_d;
  logic [LW-1:0]        res_lvl_q, res_lvl_d;
  logic [CW-1:0]        res_cnt_q, res_cnt_d;
  logic                 res_over_q, res_over_d;
  logic [LW+1:0]        lvl_ext;
  logic [CW+3:0]        cnt_ext;

  assign busy = (state_q != ST_IDLE);

  // Transmit priorities beyond the last level fold onto it.
  assign prio_sat = (32'(priority_req_i) >= LEVELS) ? LW'(LEVELS - 1) : LW'(priority_req_i);

  // Store the low MSG_WIDTH bits; zero-fill when the slots are wider.
  assign msg_in_ext = {{MSG_WIDTH{1'b0}}, message_i};

  // Stored words return sign-extended and cut to the 32-bit port.
  assign rd_ext = {{32{rd_data[MSG_WIDTH-1]}}, rd_data};

  pmbo_ptrs #(
    .LEVELS    (LEVELS),
    .RING_DEPTH(RING_DEPTH),
    .LW        (LW),
    .PW        (PW),
    .CW        (CW)
  ) u_ptrs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .level_i(lvl_q),
    .op_i   (ptr_op),
    .head_o (head),
    .tail_o (tail),
    .count_o(count),
    .full_o (full)
  );

  pmbo_mem #(
    .LEVELS    (LEVELS),
    .RING_DEPTH(RING_DEPTH),
    .MSG_WIDTH (MSG_WIDTH),
    .LW        (LW),
    .PW        (PW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_level_i(lvl_q),
    .wr_pos_i  (tail),
    .wr_data_i (msg_q),
    .rd_en_i   (mem_re),
    .rd_level_i(lvl_q),
    .rd_pos_i  (head),
    .rd_data_o (rd_data)
  );

  // Sequencer: push directly, or scan levels one per cycle and then read or report empty.
  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    ptr_op      = PTR_HOLD;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    done_d      = 1'b0;
    res_msg_d   = res_msg_q;
    res_empty_d = res_empty_q;
    res_lvl_d   = res_lvl_q;
    res_cnt_d   = res_cnt_q;
    res_over_d  = res_over_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = mode_i ? ST_SCAN : ST_PUSH;
          lvl_d   = mode_i ? '0 : prio_sat;
        end
      end
      ST_PUSH: begin
        mem_we      = 1'b1;
        ptr_op      = PTR_PUSH;
        done_d      = 1'b1;
        res_msg_d   = '0;
        res_empty_d = 1'b0;
        res_lvl_d   = lvl_q;
        res_cnt_d   = full ? count : count + CW'(1);
        res_over_d  = full;
        state_d     = ST_IDLE;
      end
      ST_SCAN: begin
        if (count != '0) begin
          mem_re  = 1'b1;
          state_d = ST_READ;
        end else if (lvl_q == LW'(LEVELS - 1)) begin
          // Every ring is empty.
          done_d      = 1'b1;
          res_msg_d   = '0;
          res_empty_d = 1'b1;
          res_lvl_d   = '0;
          res_cnt_d   = '0;
          res_over_d  = 1'b0;
          state_d     = ST_IDLE;
        end else begin
          lvl_d = lvl_q + LW'(1);
        end
      end
      ST_READ: begin
        ptr_op      = PTR_POP;
        done_d      = 1'b1;
        res_msg_d   = rd_ext[31:0];
        res_empty_d = 1'b0;
        res_lvl_d   = lvl_q;
        res_cnt_d   = count - CW'(1);
        res_over_d  = 1'b0;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lvl_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      done_q  <= done_d;
    end
  end

  // Transaction payload and result registers.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start) begin
      msg_q <= msg_in_ext[MSG_WIDTH-1:0];
    end
    res_msg_q   <= res_msg_d;
    res_empty_q <= res_empty_d;
    res_lvl_q   <= res_lvl_d;
    res_cnt_q   <= res_cnt_d;
    res_over_q  <= res_over_d;
  end

  // Fit the internal widths to the result ports.
  assign lvl_ext = {2'b00, res_lvl_q};
  assign cnt_ext = {4'b0000, res_cnt_q};

  assign done_o            = done_q;
  assign out_message_o     = res_msg_q;
  assign no_message_o      = res_empty_q;
  assign served_priority_o = lvl_ext[1:0];
  assign stored_count_o    = cnt_ext[3:0];
  assign overwrote_o       = res_over_q;

endmodule
